// ===== src/id3v2_tag_frame_parser_unit_assert.svh =====
// Assertion macros used by the checker file of the tag parser.
`ifndef ID3V2_TAG_FRAME_PARSER_UNIT_ASSERT_SVH
`define ID3V2_TAG_FRAME_PARSER_UNIT_ASSERT_SVH

// Clocked check, muted while reset is high.
`define ID3P_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked check that also runs through reset.
`define ID3P_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== src/id3p_pkg.sv =====
// Package of the tag parser: parse phases, result kinds, frame constants and the result record.
`timescale 1ns / 1ps
package id3p_pkg;

   typedef enum logic [2:0] {
      PH_TAG   = 3'd0,
      PH_ID    = 3'd1,
      PH_SIZE  = 3'd2,
      PH_FLAGS = 3'd3,
      PH_ENC   = 3'd4,
      PH_PAY   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_TAG     = 2'd0,
      KIND_FRAME   = 2'd1,
      KIND_PAYLOAD = 2'd2
   } kind_type;

   localparam logic [31:0] COMM_ID    = 32'h434F_4D4D;
   localparam logic [7:0]  SPACE_BYTE = 8'h20;

   typedef struct packed {
      kind_type     result_kind;
      logic [23:0]  signature;
      logic [7:0]   tag_version;
      logic [3:0]   tag_flags;
      logic [29:0]  tag_size;
      logic [31:0]  frame_id;
      logic [29:0]  payload_count;
      logic [15:0]  frame_flags;
      logic [7:0]   text_encoding;
      logic [7:0]   payload_byte;
      logic         payload_last;
   } rsp_data_type;

endpackage

// ===== src/id3p_channels.sv =====
// Handshake channel interfaces: stream byte input and parse result output.
`timescale 1ns / 1ps
interface id3p_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

interface id3p_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [23:0] signature;
   logic [7:0]  tag_version;
   logic [3:0]  tag_flags;
   logic [29:0] tag_size;
   logic [31:0] frame_id;
   logic [29:0] payload_count;
   logic [15:0] frame_flags;
   logic [7:0]  text_encoding;
   logic [7:0]  payload_byte;
   logic        payload_last;

   modport source (output valid, input ready, output result_kind, output signature,
                   output tag_version, output tag_flags, output tag_size,
                   output frame_id, output payload_count, output frame_flags,
                   output text_encoding, output payload_byte, output payload_last);
   modport sink (input valid, output ready, input result_kind, input signature,
                 input tag_version, input tag_flags, input tag_size,
                 input frame_id, input payload_count, input frame_flags,
                 input text_encoding, input payload_byte, input payload_last);
endinterface

// ===== src/id3v2_tag_frame_parser_unit.sv =====
// Top level of the tag header and frame parser.
`timescale 1ns / 1ps
// Takes one tag stream byte per cycle while the sink keeps up with the results, and
// returns one result per header, frame header or payload byte. A byte lands in
// an input register and is then parsed, its result going into the result
// register. The parse state is updated in that single parse step, which sets
// the one-byte-per-cycle rate. Bytes that give no result never wait; a byte
// that gives one waits only while the result register holds a beat the sink
// has not taken, and meanwhile it stays in the input register and no further
// byte is taken. No clearing pass after reset.
module id3v2_tag_frame_parser_unit
   import id3p_pkg::*;
(
   input logic         clock,
   input logic         reset,
   id3p_req_if.sink    req_chan,
   id3p_rsp_if.source  rsp_chan
);

   function automatic logic [29:0] size_term(input logic [7:0] b, input logic [1:0] idx);
      logic [29:0] wide;
      begin
         wide = {22'd0, b};
         unique case (idx)
            2'd0: size_term = wide << 21;
            2'd1: size_term = wide << 14;
            2'd2: size_term = wide << 7;
            default: size_term = wide;
         endcase
      end
   endfunction

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   phase_type    phase_ff, phase_in;
   logic [3:0]   pos_ff, pos_in;
   logic [7:0]   version_ff, version_in;
   logic [23:0]  sig_ff, sig_in;
   logic [3:0]   tflags_ff, tflags_in;
   logic [29:0]  acc_ff, acc_in;
   logic [31:0]  fid_ff, fid_in;
   logic [15:0]  fflags_ff, fflags_in;
   logic [29:0]  remain_ff, remain_in;
   logic [2:0]   pidx_ff, pidx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data;

   logic         has_result;
   logic         proc;
   logic         tag_done, id_done, size_done, flags_done;
   logic [29:0]  acc_sum, frame_count, remain_dec;

   assign tag_done   = (pos_ff == 4'd9);
   assign id_done    = (version_ff >= 8'd3) ? (pos_ff == 4'd3) : (pos_ff == 4'd2);
   assign size_done  = (pos_ff == 4'd3);
   assign flags_done = (pos_ff == 4'd1);
   assign frame_count = (acc_ff == 30'd0) ? 30'd0 : (acc_ff - 30'd1);
   assign remain_dec  = (remain_ff == 30'd0) ? 30'd0 : (remain_ff - 30'd1);

   always_comb begin
      unique case (phase_ff)
         PH_ID, PH_SIZE, PH_FLAGS: has_result = 1'b0;
         PH_ENC, PH_PAY:           has_result = 1'b1;
         default:                  has_result = tag_done;
      endcase
   end

   assign proc = in_valid_ff && (!has_result || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || proc;

   always_comb begin
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // next phase
   always_comb begin
      unique case (phase_ff)
         PH_ID:    phase_in = id_done ? PH_SIZE : PH_ID;
         PH_SIZE:  phase_in = size_done ? PH_FLAGS : PH_SIZE;
         PH_FLAGS: phase_in = flags_done ? PH_ENC : PH_FLAGS;
         PH_ENC:   phase_in = (frame_count != 30'd0) ? PH_PAY : PH_ID;
         PH_PAY:   phase_in = (remain_dec == 30'd0) ? PH_ID : PH_PAY;
         default:  phase_in = tag_done ? PH_ID : PH_TAG;
      endcase
   end

   // datapath and result
   always_comb begin
      pos_in     = pos_ff;
      version_in = version_ff;
      sig_in     = sig_ff;
      tflags_in  = tflags_ff;
      acc_in     = acc_ff;
      fid_in     = fid_ff;
      fflags_in  = fflags_ff;
      remain_in  = remain_ff;
      pidx_in    = pidx_ff;
      rsp_data   = '0;
      acc_sum    = acc_ff + size_term(in_byte_ff, pos_ff[1:0]);
      unique case (phase_ff)
         PH_ID: begin
            fid_in = {fid_ff[23:0], in_byte_ff};
            pos_in = pos_ff + 4'd1;
            if (id_done) begin
               pos_in = 4'd0;
               acc_in = 30'd0;
            end
         end
         PH_SIZE: begin
            acc_in = acc_sum;
            pos_in = pos_ff + 4'd1;
            if (size_done) begin
               pos_in    = 4'd0;
               fflags_in = 16'd0;
            end
         end
         PH_FLAGS: begin
            fflags_in = {fflags_ff[7:0], in_byte_ff};
            pos_in    = flags_done ? 4'd0 : (pos_ff + 4'd1);
         end
         PH_ENC: begin
            remain_in              = frame_count;
            rsp_data.result_kind   = KIND_FRAME;
            rsp_data.frame_id      = fid_ff;
            rsp_data.payload_count = frame_count;
            rsp_data.frame_flags   = fflags_ff;
            rsp_data.text_encoding = in_byte_ff;
            pos_in  = 4'd0;
            pidx_in = 3'd0;
            if (frame_count == 30'd0) begin
               fid_in    = 32'd0;
               acc_in    = 30'd0;
               fflags_in = 16'd0;
            end
         end
         PH_PAY: begin
            rsp_data.result_kind  = KIND_PAYLOAD;
            rsp_data.payload_byte = (pidx_ff == 3'd3 && fid_ff == COMM_ID) ? SPACE_BYTE
                                                                          : in_byte_ff;
            rsp_data.payload_last = (remain_dec == 30'd0);
            if (pidx_ff < 3'd4) begin
               pidx_in = pidx_ff + 3'd1;
            end
            remain_in = remain_dec;
            if (remain_dec == 30'd0) begin
               pos_in    = 4'd0;
               fid_in    = 32'd0;
               acc_in    = 30'd0;
               fflags_in = 16'd0;
            end
         end
         default: begin
            acc_sum = acc_ff + size_term(in_byte_ff, 2'(pos_ff - 4'd6));
            if (pos_ff < 4'd3) begin
               sig_in = {sig_ff[15:0], in_byte_ff};
            end else if (pos_ff == 4'd3) begin
               version_in = in_byte_ff;
            end else if (pos_ff == 4'd5) begin
               tflags_in = in_byte_ff[7:4];
               acc_in    = 30'd0;
            end else if (pos_ff >= 4'd6) begin
               acc_in = acc_sum;
            end
            pos_in = pos_ff + 4'd1;
            if (tag_done) begin
               rsp_data.result_kind = KIND_TAG;
               rsp_data.signature   = sig_in;
               rsp_data.tag_version = version_in;
               rsp_data.tag_flags   = tflags_in;
               rsp_data.tag_size    = acc_in;
               pos_in    = 4'd0;
               fid_in    = 32'd0;
               acc_in    = 30'd0;
               fflags_in = 16'd0;
            end
         end
      endcase
   end

   always_comb begin
      if (proc && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_TAG;
         pos_ff       <= 4'd0;
         version_ff   <= 8'd0;
         sig_ff       <= 24'd0;
         tflags_ff    <= 4'd0;
         acc_ff       <= 30'd0;
         fid_ff       <= 32'd0;
         fflags_ff    <= 16'd0;
         remain_ff    <= 30'd0;
         pidx_ff      <= 3'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc) begin
            phase_ff   <= phase_in;
            pos_ff     <= pos_in;
            version_ff <= version_in;
            sig_ff     <= sig_in;
            tflags_ff  <= tflags_in;
            acc_ff     <= acc_in;
            fid_ff     <= fid_in;
            fflags_ff  <= fflags_in;
            remain_ff  <= remain_in;
            pidx_ff    <= pidx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.stream_byte;
      end
      if (proc && has_result) begin
         rsp_data_ff <= rsp_data;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.result_kind   = rsp_data_ff.result_kind;
   assign rsp_chan.signature     = rsp_data_ff.signature;
   assign rsp_chan.tag_version   = rsp_data_ff.tag_version;
   assign rsp_chan.tag_flags     = rsp_data_ff.tag_flags;
   assign rsp_chan.tag_size      = rsp_data_ff.tag_size;
   assign rsp_chan.frame_id      = rsp_data_ff.frame_id;
   assign rsp_chan.payload_count = rsp_data_ff.payload_count;
   assign rsp_chan.frame_flags   = rsp_data_ff.frame_flags;
   assign rsp_chan.text_encoding = rsp_data_ff.text_encoding;
   assign rsp_chan.payload_byte  = rsp_data_ff.payload_byte;
   assign rsp_chan.payload_last  = rsp_data_ff.payload_last;

endmodule

// ===== src/id3p_checker.sv =====
// Port-level checker of the tag parser result channel, bound to the top level.
`timescale 1ns / 1ps
`include "id3v2_tag_frame_parser_unit_assert.svh"
module id3p_port_checker
   import id3p_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  result_kind,
   input logic [23:0] signature,
   input logic [7:0]  tag_version,
   input logic [7:0]  payload_byte,
   input logic        payload_last
);

   `ID3P_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp valid after reset")

   `ID3P_ASSERT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped")

   `ID3P_ASSERT(a_kind_legal, clock, reset, rsp_valid |-> (result_kind == KIND_TAG || result_kind == KIND_FRAME || result_kind == KIND_PAYLOAD), "bad result kind")

   `ID3P_ASSERT(a_payload_fields_clear, clock, reset, rsp_valid && result_kind != KIND_PAYLOAD |-> payload_byte == 8'd0 && !payload_last, "payload fields set on header beat")

   `ID3P_ASSERT(a_tag_fields_clear, clock, reset, rsp_valid && result_kind != KIND_TAG |-> signature == 24'd0 && tag_version == 8'd0, "tag fields set on non-tag beat")

endmodule

bind id3v2_tag_frame_parser_unit id3p_port_checker u_id3p_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .result_kind  (rsp_chan.result_kind),
   .signature    (rsp_chan.signature),
   .tag_version  (rsp_chan.tag_version),
   .payload_byte (rsp_chan.payload_byte),
   .payload_last (rsp_chan.payload_last)
);
